// File: sv/nested_grid_combination_generator_core_defines.svh
// ----------------------------------------------------------------------------
// nested grid combination generator assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef NESTED_GRID_COMBINATION_GENERATOR_CORE_DEFINES_SVH
`define NESTED_GRID_COMBINATION_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define NGCG_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ngcg check failed");

// next-cycle implication
`define NGCG_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ngcg check failed");

`endif

// File: sv/ngcg_pkg.sv
// ----------------------------------------------------------------------------
// ngcg_pkg
// types and constants of the nested grid combination generator
// ----------------------------------------------------------------------------
package ngcg_pkg;

  localparam int NUM_W      = 17;
  localparam int WALK_LIMIT = 64;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic        sgn;
    logic [63:0] opa;
    logic [63:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } alu_rsp_t;

  typedef enum logic [1:0] {
    MODE_CORNER,
    MODE_SINGLE,
    MODE_SKIP
  } emit_mode_t;

  typedef enum logic [5:0] {
    S_IDLE, S_LS, S_PAST, S_SPLIT,
    S_SK_INIT, S_SK_PO, S_SK_LOOP, S_SK_L1, S_SK_L2, S_SK_L3, S_SK_L4,
    S_SK_AREA, S_SK_TOT, S_SK_R,
    S_MG_PV, S_MG_SK, S_MG_TEST, S_MG_CMP, S_MG_A, S_MG_B, S_MG_C,
    S_MG_D, S_MG_E, S_MG_F, S_MG_END,
    S_TB_INIT, S_TB_PV, S_TB_P0, S_TB_TEST, S_TB_A, S_TB_B, S_TB_C,
    S_TB_D, S_TB_E, S_TB_F, S_TB_END,
    S_FIN, S_FIN2, S_NUM, S_NUM_SK, S_EMIT, S_WAIT
  } seq_state_t;

endpackage

// File: sv/ngcg_alu.sv
// ----------------------------------------------------------------------------
// ngcg_alu
// shared 64-bit shift-add multiplier and restoring divider, one bit a cycle
// ----------------------------------------------------------------------------
module ngcg_alu (
  input  logic              clk,
  input  logic              rst,
  input  ngcg_pkg::alu_req_t req,
  output ngcg_pkg::alu_rsp_t rsp
);
  import ngcg_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  alu_op_t     op_r;
  logic [64:0] acc;
  logic [63:0] sh;
  logic [63:0] mp;
  logic        neg_q;
  logic        neg_r;
  logic        done;
  logic [63:0] quot;
  logic [63:0] rem;

  logic [64:0] r_sh;
  logic        fits;
  logic [64:0] r_nx;
  logic [63:0] q_nx;
  logic [63:0] add_nx;
  logic [63:0] ua;
  logic [63:0] ub;

  always_comb begin
    r_sh   = {acc[63:0], sh[63]};
    fits   = r_sh >= {1'b0, mp};
    r_nx   = fits ? (r_sh - {1'b0, mp}) : r_sh;
    q_nx   = {sh[62:0], fits};
    add_nx = acc[63:0] + (mp[0] ? sh : 64'd0);
    ua     = (req.sgn && req.opa[63]) ? (64'd0 - req.opa) : req.opa;
    ub     = (req.sgn && req.opb[63]) ? (64'd0 - req.opb) : req.opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      acc   <= '0;
      neg_q <= req.sgn & (req.opa[63] ^ req.opb[63]);
      neg_r <= req.sgn & req.opa[63];
      if (req.op == ALU_DIV) begin
        sh <= ua;
        mp <= ub;
      end else begin
        sh <= req.opa;
        mp <= req.opb;
      end
    end else if (busy) begin
      if (op_r == ALU_DIV) begin
        acc <= r_nx;
        sh  <= q_nx;
      end else begin
        acc <= {1'b0, add_nx};
        sh  <= sh << 1;
        mp  <= mp >> 1;
      end
      if (cnt == 6'd63) begin
        if (op_r == ALU_DIV) begin
          quot <= neg_q ? (64'd0 - q_nx) : q_nx;
          rem  <= neg_r ? (64'd0 - r_nx[63:0]) : r_nx[63:0];
        end else begin
          quot <= add_nx;
          rem  <= '0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

// File: sv/ngcg_seq.sv
// ----------------------------------------------------------------------------
// ngcg_seq
// sequencer: layer search, skip-offset walks and per-dimension result output
// ----------------------------------------------------------------------------
module ngcg_seq #(
  parameter int MAX_DIMS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(MAX_DIMS+1)-1:0]   d_eff,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     seq_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      dim_pos,
  output logic [ngcg_pkg::NUM_W-1:0]      numerator,
  output logic [ngcg_pkg::NUM_W-1:0]      set_size,
  output logic                            last,
  output ngcg_pkg::alu_req_t              req,
  input  ngcg_pkg::alu_rsp_t              rsp
);
  import ngcg_pkg::*;

  localparam int DW = $clog2(MAX_DIMS + 1);

  seq_state_t state, state_next, ret, ret_next;
  emit_mode_t mode;

  logic [31:0]       inc;
  logic [DW-1:0]     d;
  logic [DW-1:0]     k;
  logic [5:0]        lyr;
  logic [63:0]       p;
  logic [63:0]       lv;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  size;
  logic [6:0]        n;
  logic              done_f;

  logic signed [63:0] pe, msingle, mmul, tsingle, tmul, mnum, msum, tsum;
  logic signed [63:0] endn, tnum, marea, tarea, aoff, idx, qtot, acc;
  logic signed [63:0] pv, pf, skip, prev, blk, rmd, res;

  logic [5:0]         lm1;
  logic [63:0]        e_u;
  logic signed [63:0] e_s, o_s, a_s;
  logic [63:0]        a_u;
  logic [DW-1:0]      dm1, dm2;
  logic [11:0]        sh_pe, sh_sk, sh_sg;
  logic signed [63:0] q_s, r_s, total_c, endn_nx;
  logic [63:0]        single;
  logic               corner_in, ls_more, ls_hit, sgl, mg_go, tb_go;

  always_comb begin
    lm1       = lyr - 6'd1;
    e_u       = 64'd1 << lm1;
    a_u       = (64'd1 << lyr) + 64'd1;
    e_s       = $signed(e_u);
    o_s       = $signed(e_u + 64'd1);
    a_s       = $signed(a_u);
    dm1       = d - DW'(1);
    dm2       = d - DW'(2);
    sh_pe     = 12'(lm1) * (12'(d) - 12'd2);
    sh_sk     = 12'(lm1) * (12'(d) - 12'd1);
    sh_sg     = 12'(lm1) * 12'(d);
    single    = 64'd1 << sh_sg;
    q_s       = $signed(rsp.quot);
    r_s       = $signed(rsp.rem);
    total_c   = marea + tarea;
    endn_nx   = endn + mnum;
    corner_in = (32'(d_eff) >= 32) || (64'(seq_index) < (64'd1 << d_eff));
    ls_more   = (k < d) && (p <= 64'hFFFF_FFFF);
    ls_hit    = (p > 64'(inc)) || (lyr == 6'd31);
    sgl       = lv < single;
    mg_go     = (pf > 64'sd0) && (n < 7'(WALK_LIMIT));
    tb_go     = !done_f && (n < 7'(WALK_LIMIT)) && (pf > 64'sd0);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (32'(d_eff) < 2)  state_next = S_IDLE;
          else if (corner_in)  state_next = S_NUM;
          else                 state_next = S_LS;
        end
      end
      S_LS:      if (!ls_more && ls_hit) state_next = S_PAST;
      S_PAST:    if (k >= d) state_next = S_SPLIT;
      S_SPLIT:   state_next = sgl ? S_NUM : S_SK_INIT;
      S_SK_INIT: state_next = S_SK_PO;
      S_SK_PO:   if (k >= dm2) state_next = S_SK_LOOP;
      S_SK_LOOP: state_next = (k < dm2) ? S_WAIT : S_SK_AREA;
      S_SK_L1, S_SK_L2, S_SK_L3: state_next = S_WAIT;
      S_SK_L4:   state_next = S_SK_LOOP;
      S_SK_AREA: state_next = S_SK_TOT;
      S_SK_TOT:  state_next = (total_c <= 64'sd0) ? S_NUM : S_WAIT;
      S_SK_R:    state_next = (r_s < marea) ? S_MG_PV : S_TB_INIT;
      S_MG_PV:   if (k >= dm1) state_next = S_MG_SK;
      S_MG_SK:   if (k >= dm1) state_next = S_MG_TEST;
      S_MG_TEST: state_next = mg_go ? S_WAIT : S_MG_END;
      S_MG_CMP:  state_next = (r_s < (pf - pv)) ? S_WAIT : S_MG_END;
      S_MG_A, S_MG_B, S_MG_D, S_MG_E: state_next = S_WAIT;
      S_MG_C:    state_next = (pf <= 64'sd0) ? S_MG_END : S_WAIT;
      S_MG_F:    state_next = S_MG_TEST;
      S_MG_END:  state_next = S_FIN;
      S_TB_INIT: state_next = (idx < endn) ? S_FIN : S_TB_PV;
      S_TB_PV:   if (k >= dm2) state_next = S_WAIT;
      S_TB_P0:   state_next = S_TB_TEST;
      S_TB_TEST: state_next = tb_go ? S_WAIT : S_TB_END;
      S_TB_A, S_TB_B, S_TB_C, S_TB_D, S_TB_E: state_next = S_WAIT;
      S_TB_F:    state_next = S_TB_TEST;
      S_TB_END:  state_next = S_FIN;
      S_FIN:     state_next = S_WAIT;
      S_FIN2:    state_next = S_NUM;
      S_NUM:     state_next = (mode == MODE_SKIP) ? S_WAIT : S_EMIT;
      S_NUM_SK:  state_next = S_EMIT;
      S_EMIT: begin
        if (out_ready) state_next = (k == dm1) ? S_IDLE : S_NUM;
      end
      S_WAIT:    if (rsp.done) state_next = ret;
      default:   state_next = S_IDLE;
    endcase
  end

  // shared unit requests
  always_comb begin
    req.start = 1'b0;
    req.op    = ALU_DIV;
    req.sgn   = 1'b1;
    req.opa   = '0;
    req.opb   = '0;
    ret_next  = ret;
    case (state)
      S_SK_LOOP: if (k < dm2) begin
        req.start = 1'b1; req.opa = tmul; req.opb = e_s; ret_next = S_SK_L1;
      end
      S_SK_L1: begin
        req.start = 1'b1; req.op = ALU_MUL; req.opa = tnum; req.opb = q_s;
        ret_next = S_SK_L2;
      end
      S_SK_L2: begin
        req.start = 1'b1; req.opa = mmul; req.opb = o_s; ret_next = S_SK_L3;
      end
      S_SK_L3: begin
        req.start = 1'b1; req.op = ALU_MUL; req.opa = mnum; req.opb = q_s;
        ret_next = S_SK_L4;
      end
      S_SK_TOT: if (total_c > 64'sd0) begin
        req.start = 1'b1; req.opa = idx; req.opb = total_c; ret_next = S_SK_R;
      end
      S_MG_TEST: if (mg_go) begin
        req.start = 1'b1; req.opa = idx; req.opb = pf; ret_next = S_MG_CMP;
      end
      S_MG_CMP: if (r_s < (pf - pv)) begin
        req.start = 1'b1; req.opa = pv; req.opb = a_s; ret_next = S_MG_A;
      end
      S_MG_A: begin
        req.start = 1'b1; req.opa = pf - (q_s <<< lyr); req.opb = o_s;
        ret_next = S_MG_B;
      end
      S_MG_B: begin
        req.start = 1'b1; req.opa = skip; req.opb = o_s; ret_next = S_MG_C;
      end
      S_MG_C: if (pf > 64'sd0) begin
        req.start = 1'b1; req.opa = idx; req.opb = pf; ret_next = S_MG_D;
      end
      S_MG_D: begin
        req.start = 1'b1; req.opa = idx + pv; req.opb = pf; ret_next = S_MG_E;
      end
      S_MG_E: begin
        req.start = 1'b1; req.op = ALU_MUL; req.opa = q_s; req.opb = skip;
        ret_next = S_MG_F;
      end
      S_TB_PV: if (k >= dm2) begin
        req.start = 1'b1; req.opa = tarea - $signed(p); req.opb = e_s;
        ret_next = S_TB_P0;
      end
      S_TB_TEST: if (tb_go) begin
        req.start = 1'b1; req.opa = idx; req.opb = pf; ret_next = S_TB_A;
      end
      S_TB_A: begin
        req.start = 1'b1; req.opa = skip; req.opb = e_s; ret_next = S_TB_B;
      end
      S_TB_B: begin
        req.start = 1'b1; req.opa = idx + pv; req.opb = pf; ret_next = S_TB_C;
      end
      S_TB_C: begin
        req.start = 1'b1; req.op = ALU_MUL; req.opa = q_s; req.opb = skip;
        ret_next = S_TB_D;
      end
      S_TB_D: begin
        req.start = 1'b1; req.opa = pv; req.opb = a_s; ret_next = S_TB_E;
      end
      S_TB_E: begin
        req.start = 1'b1; req.opa = pf - prev + q_s; req.opb = e_s;
        ret_next = S_TB_F;
      end
      S_FIN: begin
        req.start = 1'b1; req.op = ALU_MUL; req.opa = qtot; req.opb = aoff <<< 1;
        ret_next = S_FIN2;
      end
      S_NUM: if (mode == MODE_SKIP) begin
        req.start = 1'b1; req.sgn = 1'b0; req.opa = lv; req.opb = a_u;
        ret_next = S_NUM_SK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) begin
        inc  <= seq_index;
        d    <= d_eff;
        k    <= '0;
        lyr  <= 6'd1;
        p    <= 64'd1;
        mode <= MODE_CORNER;
        size <= NUM_W'(2);
      end
      S_LS: begin
        if (ls_more) begin
          p <= (p << lyr) + p;
          k <= k + DW'(1);
        end else begin
          if (!ls_hit) lyr <= lyr + 6'd1;
          k <= '0;
          p <= 64'd1;
        end
      end
      S_PAST: begin
        if (k < d) begin
          p <= (p << lm1) + p;
          k <= k + DW'(1);
        end else begin
          lv <= 64'(inc) - p;
        end
      end
      S_SPLIT: begin
        k    <= '0;
        size <= NUM_W'(a_u);
        mode <= MODE_SINGLE;
        idx  <= $signed(lv - single);
      end
      S_SK_INIT: begin
        pe <= 64'sd1 <<< sh_pe;
        p  <= 64'd1;
        k  <= '0;
      end
      S_SK_PO: begin
        if (k < dm2) begin
          p <= (p << lm1) + p;
          k <= k + DW'(1);
        end else begin
          msingle <= $signed(p) <<< lm1;
          mmul    <= $signed(p) <<< lm1;
          tsingle <= (pe <<< lm1) - pe;
          tmul    <= (pe <<< lm1) - pe;
          mnum    <= a_s;
          msum    <= '0;
          tsum    <= '0;
          endn    <= 64'sd1;
          k       <= '0;
        end
      end
      S_SK_LOOP: if (k < dm2) begin
        endn <= endn_nx;
        tnum <= (endn_nx <<< 1) - mnum;
      end
      S_SK_L1: tmul <= q_s;
      S_SK_L2: tsum <= tsum + q_s;
      S_SK_L3: mmul <= q_s;
      S_SK_L4: begin
        msum <= msum + q_s;
        mnum <= (mnum <<< lyr) + mnum;
        k    <= k + DW'(1);
      end
      S_SK_AREA: begin
        marea <= msingle + msum;
        tarea <= tsingle + tsum + (endn <<< 1);
        aoff  <= tsingle + tsum + (endn <<< 1) + (pe <<< lm1);
      end
      S_SK_TOT: if (total_c <= 64'sd0) begin
        lv   <= '0;
        mode <= MODE_SKIP;
        k    <= '0;
      end
      S_SK_R: begin
        qtot <= q_s;
        k    <= '0;
        p    <= 64'd1;
        idx  <= (r_s < marea) ? r_s : (r_s - marea);
      end
      S_MG_PV: begin
        if (k < dm1) begin
          p <= (p << lyr) + p;
          k <= k + DW'(1);
        end else begin
          pv <= $signed(p);
          pf <= marea + $signed(p);
          k  <= '0;
          p  <= 64'd1;
        end
      end
      S_MG_SK: begin
        if (k < dm1) begin
          p <= (p << lm1) + p;
          k <= k + DW'(1);
        end else begin
          skip <= $signed(p);
          acc  <= '0;
          n    <= '0;
        end
      end
      S_MG_A: pv <= q_s;
      S_MG_B: pf <= q_s;
      S_MG_C: skip <= q_s;
      S_MG_D: begin
        blk <= idx - r_s;
        idx <= r_s;
      end
      S_MG_F: begin
        acc <= acc + q_s + blk;
        n   <= n + 7'd1;
      end
      S_MG_END: res <= acc + idx;
      S_TB_INIT: begin
        res <= idx + aoff;
        k   <= '0;
        p   <= 64'd1;
      end
      S_TB_PV: begin
        if (k < dm2) begin
          p <= (p << lyr) + p;
          k <= k + DW'(1);
        end else begin
          pv     <= (endn <<< 1) - $signed(p);
          idx    <= idx - endn;
          skip   <= 64'sd1 <<< sh_sk;
          acc    <= '0;
          n      <= '0;
          done_f <= 1'b0;
        end
      end
      S_TB_P0: pf <= q_s;
      S_TB_A: begin
        blk <= idx - r_s;
        rmd <= r_s;
        if (r_s >= (pf - pv)) done_f <= 1'b1;
      end
      S_TB_B: begin
        skip <= q_s;
        idx  <= rmd;
      end
      S_TB_D: begin
        acc  <= acc + q_s + blk;
        prev <= pv;
      end
      S_TB_E: pv <= q_s;
      S_TB_F: begin
        pf <= q_s;
        n  <= n + 7'd1;
      end
      S_TB_END: res <= acc + idx + endn + aoff;
      S_FIN2: begin
        lv   <= $unsigned(res + q_s);
        mode <= MODE_SKIP;
        k    <= '0;
      end
      S_NUM: begin
        if (mode == MODE_CORNER) begin
          num <= NUM_W'(inc >> k) & NUM_W'(1);
        end else if (mode == MODE_SINGLE) begin
          num <= NUM_W'((lv & (e_u - 64'd1)) << 1) | NUM_W'(1);
          lv  <= lv >> lm1;
        end
      end
      S_NUM_SK: begin
        num <= rsp.rem[NUM_W-1:0];
        lv  <= rsp.quot;
      end
      S_EMIT: if (out_ready && (k != dm1)) k <= k + DW'(1);
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign dim_pos   = 3'(k);
  assign numerator = num;
  assign set_size  = size;
  assign last      = (k == dm1);

endmodule

// File: sv/nested_grid_combination_generator_core.sv
// ----------------------------------------------------------------------------
// nested_grid_combination_generator_core
// decodes a sequence index into one point of a nested dyadic grid
// ----------------------------------------------------------------------------
// One index at a time. Corner indexes go straight to the output; other
// indexes first run a layer search. Single group indexes then go to the
// output. Skip-offset indexes go on to the walks on one shared 64-bit
// multiply/divide unit, so their run time depends on the layer and the walk
// depth. Results leave one per dimension, each held until its transfer; the
// next index is taken after the last result of the point.
module nested_grid_combination_generator_core #(
  parameter int MAX_DIMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] seq_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  dim_pos,
  output logic [16:0] numerator,
  output logic [16:0] set_size,
  output logic        last
);
  import ngcg_pkg::*;

  localparam int DW = $clog2(MAX_DIMS + 1);

  logic [3:0]    dims;
  logic [DW-1:0] d_eff;
  alu_req_t      req;
  alu_rsp_t      rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= 4'd2;
    end else if (cfg_we) begin
      dims <= cfg_wdata;
    end
  end

  // clamp to the supported dimension count
  assign d_eff = (32'(dims) > MAX_DIMS) ? DW'(MAX_DIMS) : DW'(dims);

  ngcg_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  ngcg_seq #(
    .MAX_DIMS (MAX_DIMS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .d_eff     (d_eff),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .seq_index (seq_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dim_pos   (dim_pos),
    .numerator (numerator),
    .set_size  (set_size),
    .last      (last),
    .req       (req),
    .rsp       (rsp)
  );

endmodule

// File: sv/ngcg_checker.sv
// ----------------------------------------------------------------------------
// ngcg_checker
// port-level checks of the nested grid combination generator
// ----------------------------------------------------------------------------
`include "nested_grid_combination_generator_core_defines.svh"

module ngcg_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic last
);

  // a stalled result stays offered
  `NGCG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // no new index while a result is offered
  `NGCG_ASSERT_NOW(a_busy_out, clk, rst, out_valid, !in_ready)

  // the point ends after the last transfer
  `NGCG_ASSERT_NEXT(a_last_end, clk, rst, out_valid && out_ready && last, !out_valid)

  // more results follow before a new index
  `NGCG_ASSERT_NEXT(a_mid_busy, clk, rst, out_valid && out_ready && !last, !in_ready)

endmodule

bind nested_grid_combination_generator_core ngcg_checker u_ngcg_checker (.*);

// File: bench/nested_grid_combination_generator_core_test.sv
// ----------------------------------------------------------------------------
// nested_grid_combination_generator_core_test
// checks decoded grid coordinates against an in-bench coordinate predictor
// ----------------------------------------------------------------------------
// Sequence indexes are sent over the valid/ready input. For each accepted index
// the expected per-dimension numerators and set size are worked out from the
// dimension count in force. Every result transfer is checked against the oldest
// expected coordinate. Dimension counts from 0 to 15 are used, and indexes cover
// corner points, layer boundaries, the single group and the skip-offset walks.
// Sender gaps and receiver stalls vary from phase to phase.
module nested_grid_combination_generator_core_test;
  import ngcg_pkg::*;

  localparam int  MAX_D      = 8;
  localparam int  DRAIN_CYC  = 20000;
  localparam longint unsigned MASK17 = 64'h1FFFF;

  typedef struct {
    logic [2:0]  dim_pos;
    logic [16:0] numerator;
    logic [16:0] set_size;
    logic        last;
  } coord_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] seq_index;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  dim_pos;
  logic [16:0] numerator;
  logic [16:0] set_size;
  logic        last;

  coord_t expected_coords[$];
  logic [3:0] dims_reg;
  int idle_pct;
  int stall_pct;
  int mismatches;
  int indexes_sent;
  int coords_checked;

  nested_grid_combination_generator_core #(.MAX_DIMS(MAX_D)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .seq_index (seq_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dim_pos   (dim_pos),
    .numerator (numerator),
    .set_size  (set_size),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d coordinates outstanding", expected_coords.size());
    $display("== FAIL ==");
    $finish;
  end

  // grid arithmetic

  function automatic longint int_pow(longint b, int e);
    longint r;
    r = 1;
    for (int i = 0; i < e; i++) r = r * b;
    return r;
  endfunction

  function automatic longint magnitude_walk(int d, longint a, longint area, longint idx);
    longint osz, pv, pf, skip, acc, blk;
    int n;
    osz  = (a - 1) / 2 + 1;
    pv   = int_pow(a, d - 1);
    pf   = area + pv;
    skip = int_pow(osz, d - 1);
    acc  = 0;
    n    = 0;
    while (pf > 0 && n < WALK_LIMIT && (idx % pf) < pf - pv) begin
      pv   = pv / a;
      pf   = (pf - pv * a + pv) / osz;
      skip = skip / osz;
      if (pf <= 0) break;
      blk = idx / pf * pf;
      acc = acc + (idx + pv) / pf * skip + blk;
      idx = idx - blk;
      n++;
    end
    return acc + idx;
  endfunction

  function automatic longint turbulent_walk(int d, longint a, longint e, longint area,
                                            longint endn, longint idx);
    longint pv, pf, skip, blk, prev, acc;
    bit done;
    int n;
    if (idx < endn) return idx;
    acc  = 0;
    done = 1'b0;
    n    = 0;
    pv   = endn + (endn - int_pow(a, d - 2));
    pf   = (area - endn * 2 + pv) / e;
    skip = int_pow(e, d - 1);
    idx  = idx - endn;
    while (!done && n < WALK_LIMIT) begin
      if (pf <= 0) break;
      blk = idx / pf * pf;
      if (idx - blk >= pf - pv) done = 1'b1;
      skip = skip / e;
      acc  = acc + (idx + pv) / pf * skip + blk;
      idx  = idx - blk;
      prev = pv;
      pv   = pv / a;
      pf   = (pf - prev + pv) / e;
      n++;
    end
    return acc + idx + endn;
  endfunction

  function automatic longint skip_offset(int d, int layer, longint idx);
    longint p, e, o, a, pe, po, mnum, msum, msingle, mmul;
    longint tnum, tsum, tsingle, tmul, endn, marea, tarea, aoff, total, r, res;
    p = longint'(1) << layer;
    e = p / 2;
    o = e + 1;
    a = p + 1;
    pe = int_pow(e, d - 2);
    po = int_pow(o, d - 2);
    mnum = a; msum = 0; msingle = po * e; mmul = msingle;
    tsum = 0; tsingle = pe * (e - 1); tmul = tsingle;
    endn = 1;
    for (int i = 0; i < d - 2; i++) begin
      endn = endn + mnum;
      tnum = endn + (endn - mnum);
      tmul = tmul / e;
      tsum = tsum + tnum * tmul;
      mmul = mmul / o;
      msum = msum + mnum * mmul;
      mnum = mnum * a;
    end
    marea = msingle + msum;
    tarea = tsingle + tsum + endn * 2;
    aoff  = tarea + pe * e;
    total = marea + tarea;
    if (total <= 0) return 0;
    r = idx % total;
    if (r < marea) res = magnitude_walk(d, a, marea, r);
    else res = turbulent_walk(d, a, e, tarea, endn, r - marea) + aoff;
    return res + idx / total * (aoff + aoff);
  endfunction

  function automatic void push_coord(int k, int d, longint unsigned num, longint unsigned sz);
    coord_t c;
    c.dim_pos   = k[2:0];
    c.numerator = 17'(num & MASK17);
    c.set_size  = 17'(sz & MASK17);
    c.last      = (k + 1 == d);
    expected_coords.push_back(c);
  endfunction

  function automatic void predict_point(logic [31:0] idx);
    int d, layer;
    longint unsigned inc, base, p, past, single, lv, sz;
    d = int'(dims_reg);
    if (d < 2) return;
    if (d > MAX_D) d = MAX_D;
    inc = 64'(idx);
    if (inc < (64'd1 << d)) begin
      for (int k = 0; k < d; k++) push_coord(k, d, (inc >> k) & 1, 2);
      return;
    end
    for (layer = 1; layer < 32; layer++) begin
      base = (64'd1 << layer) + 1;
      p = 1;
      for (int k = 0; k < d && p <= 64'hFFFF_FFFF; k++) p = p * base;
      if (p > inc) break;
    end
    base = (64'd1 << (layer - 1)) + 1;
    past = 1;
    for (int k = 0; k < d; k++) past = past * base;
    lv = inc - past;
    single = 64'd1 << ((layer - 1) * d);
    sz = (64'd1 << layer) + 1;
    if (lv < single) begin
      base = 64'd1 << (layer - 1);
      for (int k = 0; k < d; k++) begin
        push_coord(k, d, (lv % base) * 2 + 1, sz);
        lv = lv / base;
      end
      return;
    end
    lv = longint'(skip_offset(d, layer, longint'(lv - single)));
    for (int k = 0; k < d; k++) begin
      push_coord(k, d, lv % sz, sz);
      lv = lv / sz;
    end
  endfunction

  // result checking

  always @(posedge clk) begin
    coord_t c;
    if (!rst && out_valid && out_ready) begin
      if (expected_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected coordinate dim %0d num %0d size %0d last %0b",
                   dim_pos, numerator, set_size, last);
      end else begin
        c = expected_coords.pop_front();
        coords_checked++;
        if (c.dim_pos !== dim_pos || c.numerator !== numerator ||
            c.set_size !== set_size || c.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected dim %0d num %0d size %0d last %0b, got dim %0d num %0d size %0d last %0b",
                     c.dim_pos, c.numerator, c.set_size, c.last,
                     dim_pos, numerator, set_size, last);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // stimulus helpers

  task automatic send_index(logic [31:0] idx);
    if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 6)) @(negedge clk);
    in_valid  = 1'b1;
    seq_index = idx;
    do @(posedge clk); while (!in_ready);
    predict_point(idx);
    indexes_sent++;
    @(negedge clk);
    in_valid  = 1'b0;
    seq_index = $urandom;
  endtask

  task automatic wait_drained();
    while (expected_coords.size() != 0) @(negedge clk);
  endtask

  task automatic write_dims(logic [3:0] v);
    wait_drained();
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    dims_reg  = v;
    cfg_we    = 1'b0;
    cfg_wdata = 4'($urandom);
  endtask

  function automatic logic [31:0] pick_index();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(0, 300);
      default: return $urandom_range(0, 20000);
    endcase
  endfunction

  // tests

  task automatic test_two_dims_directed();
    idle_pct = 0; stall_pct = 0;
    send_index(0);
    send_index(3);
    send_index(4);
    send_index(8);
    send_index(9);
    send_index(24);
    send_index(25);
    send_index(80);
    send_index(32'h5555_5555);
    send_index(32'h8000_0000);
    send_index(32'hFFFF_FFFF);
  endtask

  task automatic test_no_output_dims();
    write_dims(4'd0);
    send_index(32'hFFFF_FFFF);
    send_index(5);
    write_dims(4'd1);
    send_index(7);
    send_index(32'h1234_5678);
  endtask

  task automatic test_wide_dims_directed();
    write_dims(4'd8);
    send_index(255);
    send_index(256);
    send_index(6560);
    send_index(6561);
    send_index(32'hFFFF_FFFF);
    write_dims(4'd15);
    send_index(0);
    send_index(300);
    write_dims(4'd3);
    send_index(7);
    send_index(8);
    send_index(200);
  endtask

  task automatic test_random_phases();
    logic [3:0] setting [4];
    int idle_set [4];
    int stall_set [4];
    setting = '{4'd2, 4'd8, 4'd15, 4'($urandom_range(3, 7))};
    idle_set  = '{0, 64, 0, 6};
    stall_set = '{0, 0, 64, 6};
    for (int ph = 0; ph < 4; ph++) begin
      write_dims(setting[ph]);
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int i = 0; i < 50; i++) begin
        if (ph == 2 && i == 25) wait_drained();
        send_index(pick_index());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; seq_index = '0;
    out_ready = 1'b0;
    dims_reg = 4'd2;
    idle_pct = 0; stall_pct = 0;
    mismatches = 0; indexes_sent = 0; coords_checked = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_two_dims_directed();
    test_no_output_dims();
    test_wide_dims_directed();
    test_random_phases();

    wait_drained();
    repeat (DRAIN_CYC) @(negedge clk);
    $display("sent %0d indexes over dimension counts 0 to 15, checked %0d coordinates",
             indexes_sent, coords_checked);
    $display("corner, single group and skip-offset points under sender gaps and receiver stalls");
    if (mismatches == 0 && expected_coords.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d coordinates missing", mismatches, expected_coords.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
